@@ rtl/rms_pkg.sv @@
// Shared types and constants for the route member selector.
`timescale 1ns / 1ps

package rms_pkg;

  // Fixed geometry of the member tables and the result fields.
  localparam int LANES    = 8;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 4;
  localparam int TABLE_W  = 64;
  localparam int REASON_W = 3;

  // Remainder unit: 64-bit dividend, 11-bit divisor, four bits per cycle.
  localparam int DVD_W      = 64;
  localparam int REM_W      = 11;
  localparam int DIG_BITS   = 4;
  localparam int DIG_CNT_W  = 4;
  localparam int CUR_DIGITS = (REM_W + 1) / DIG_BITS;
  localparam int CUR_LOW    = DVD_W - DIG_BITS * CUR_DIGITS;

  localparam logic [DIG_CNT_W-1:0] HASH_DIG_LAST = DIG_CNT_W'(DVD_W / DIG_BITS - 1);
  localparam logic [DIG_CNT_W-1:0] CUR_DIG_LAST  = DIG_CNT_W'(CUR_DIGITS - 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 3'd4;

  localparam logic [TABLE_W-1:0] PRIORITY_RST = 64'h6464_6464_6464_6464;
  localparam logic [TABLE_W-1:0] WEIGHT_RST   = 64'h0101_0101_0101_0101;

  // Selection policies.
  localparam logic [1:0] POL_FAILOVER    = 2'd0;
  localparam logic [1:0] POL_ROUND_ROBIN = 2'd1;
  localparam logic [1:0] POL_WEIGHTED    = 2'd2;
  localparam logic [1:0] POL_HASH        = 2'd3;

  // Result reason codes.
  localparam logic [REASON_W-1:0] RS_OK          = 3'd0;
  localparam logic [REASON_W-1:0] RS_DISABLED    = 3'd1;
  localparam logic [REASON_W-1:0] RS_NO_MEMBERS  = 3'd2;
  localparam logic [REASON_W-1:0] RS_ZERO_WEIGHT = 3'd3;
  localparam logic [REASON_W-1:0] RS_ALL_DEAD    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                sum_step;
    logic                mod_init;
    logic                mod_src_hash;
    logic                mod_step;
    logic                scan_init;
    logic                scan_step;
    logic                finish;
    logic                found;
    logic [REASON_W-1:0] reason;
    logic [IDX_W-1:0]    k;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0]       policy;
    logic             enabled;
    logic             n_zero;
    logic [IDX_W-1:0] n_last;
    logic             total_zero;
    logic             hit;
    logic             have;
  } dp_status_t;

endpackage

@@ rtl/rms_rem.sv @@
// Shared remainder unit: restoring division, four dividend bits per cycle while step_i is high.
`timescale 1ns / 1ps

module rms_rem (
  input  logic                       clk_i,
  input  logic                       init_i,
  input  logic                       step_i,
  input  logic [rms_pkg::DVD_W-1:0]  dividend_i,
  input  logic [rms_pkg::REM_W-1:0]  divisor_i,
  output logic [rms_pkg::REM_W-1:0]  rem_o
);
  import rms_pkg::*;

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [REM_W-1:0] rem_q, rem_d;

  // The remainder always stays below the divisor, so each partial value
  // fits in one bit more than the remainder.
  always_comb begin
    logic [REM_W:0] t;
    logic [REM_W-1:0] r;
    r = rem_q;
    for (int j = 0; j < DIG_BITS; j++) begin
      t = {r, dvd_q[DVD_W-1-j]};
      if (t >= {1'b0, divisor_i}) begin
        t = t - {1'b0, divisor_i};
      end
      r = t[REM_W-1:0];
    end
    rem_d = r;
    dvd_d = dvd_q << DIG_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (step_i) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;

endmodule

@@ rtl/rms_datapath.sv @@
// Datapath: configuration registers, cursor, member scans and result word.
`timescale 1ns / 1ps

module rms_datapath #(
  parameter int MAX_MEMBERS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rms_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rms_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [rms_pkg::LANES-1:0]       alive_mask_i,
  input  logic [rms_pkg::DVD_W-1:0]       hash_value_i,
  input  rms_pkg::dp_cmd_t                cmd_i,
  output rms_pkg::dp_status_t             status_o,
  output logic                            done_o,
  output logic                            found_o,
  output logic [rms_pkg::IDX_W-1:0]       member_index_o,
  output logic [rms_pkg::REASON_W-1:0]    reason_o
);
  import rms_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_MEMBERS);

  function automatic logic [7:0] byte_of(logic [TABLE_W-1:0] tbl, logic [IDX_W-1:0] i);
    return tbl[{i, 3'b000} +: 8];
  endfunction

  // Configuration and persistent state.
  logic [1:0]         policy_q;
  logic               enabled_q;
  logic [CNT_W-1:0]   count_q;
  logic [TABLE_W-1:0] prio_q;
  logic [TABLE_W-1:0] weight_q;
  logic [REM_W-1:0]   cursor_q, cursor_d;
  logic               done_q;

  // Per-request working registers.
  logic [LANES-1:0]    alive_q;
  logic [REM_W-1:0]    total_q;
  logic [REM_W-1:0]    ends_q [LANES];
  logic [IDX_W-1:0]    idx_q;
  logic [REM_W-1:0]    target_q, target0_q;
  logic [IDX_W-1:0]    best_q;
  logic [7:0]          bestp_q;
  logic                have_q;
  logic                found_q;
  logic [IDX_W-1:0]    index_q;
  logic [REASON_W-1:0] reason_q;

  logic [CNT_W-1:0]    n;
  logic [IDX_W-1:0]    n_last;
  logic [REM_W-1:0]    sum_next;
  logic [IDX_W-1:0]    wsel;
  logic [IDX_W-1:0]    sel;
  logic [REM_W-1:0]    target_inc, target0_inc;
  logic                use_idx, use_k;
  logic [DVD_W-1:0]    dividend;
  logic [REM_W-1:0]    divisor;
  logic [REM_W-1:0]    rem;

  assign n      = (count_q > MaxCnt) ? MaxCnt : count_q;
  assign n_last = IDX_W'(n - CNT_W'(1));

  assign sum_next    = total_q + REM_W'(byte_of(weight_q, cmd_i.k));
  assign target_inc  = (target_q + REM_W'(1) == total_q) ? '0 : target_q + REM_W'(1);
  assign target0_inc = (target0_q + REM_W'(1) == total_q) ? '0 : target0_q + REM_W'(1);

  assign use_idx = (byte_of(weight_q, idx_q) != 8'd0) && alive_q[idx_q];
  assign use_k   = (byte_of(weight_q, cmd_i.k) != 8'd0) && alive_q[cmd_i.k];

  // Weighted slot lookup: the first member whose cumulative weight end lies
  // above the target. A zero-weight member shares the end of the one before
  // it and can never be first.
  always_comb begin
    logic hit_any;
    hit_any = 1'b0;
    wsel    = '0;
    for (int i = 0; i < LANES; i++) begin
      if (!hit_any && (CNT_W'(i) < n) && (target_q < ends_q[i])) begin
        hit_any = 1'b1;
        wsel    = IDX_W'(i);
      end
    end
  end

  always_comb begin
    case (policy_q)
      POL_FAILOVER: sel = best_q;
      POL_WEIGHTED: sel = wsel;
      default:      sel = idx_q;
    endcase
  end

  always_comb begin
    cursor_d = cursor_q;
    if (cmd_i.finish && cmd_i.found) begin
      case (policy_q)
        POL_ROUND_ROBIN: cursor_d = (idx_q == n_last) ? '0 : REM_W'(idx_q) + REM_W'(1);
        POL_WEIGHTED:    cursor_d = target0_inc;
        default:         cursor_d = cursor_q;
      endcase
    end
  end

  // Remainder unit operands: the hash or the cursor (left-aligned into the
  // top digits), over the member count or the total weight.
  assign dividend = cmd_i.mod_src_hash ? hash_value_i :
                    {1'b0, cursor_q, {CUR_LOW{1'b0}}};
  assign divisor  = (policy_q == POL_WEIGHTED) ? total_q : REM_W'(n);

  rms_rem u_rem (
    .clk_i      (clk_i),
    .init_i     (cmd_i.mod_init),
    .step_i     (cmd_i.mod_step),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POL_FAILOVER;
      enabled_q <= 1'b1;
      count_q   <= '0;
      prio_q    <= PRIORITY_RST;
      weight_q  <= WEIGHT_RST;
      cursor_q  <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q   <= cmd_i.finish;
      cursor_q <= cursor_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_POLICY:   policy_q  <= cfg_data_i[1:0];
          CFG_ENABLED:  enabled_q <= cfg_data_i[0];
          CFG_COUNT:    count_q   <= cfg_data_i[CNT_W-1:0];
          CFG_PRIORITY: prio_q    <= cfg_data_i;
          CFG_WEIGHT:   weight_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      alive_q <= alive_mask_i;
      total_q <= '0;
      have_q  <= 1'b0;
    end
    if (cmd_i.sum_step) begin
      total_q          <= sum_next;
      ends_q[cmd_i.k]  <= sum_next;
    end
    if (cmd_i.scan_init) begin
      idx_q     <= rem[IDX_W-1:0];
      target_q  <= rem;
      target0_q <= rem;
    end
    if (cmd_i.scan_step) begin
      case (policy_q)
        POL_FAILOVER: begin
          if (use_k && (!have_q || byte_of(prio_q, cmd_i.k) < bestp_q)) begin
            have_q  <= 1'b1;
            best_q  <= cmd_i.k;
            bestp_q <= byte_of(prio_q, cmd_i.k);
          end
        end
        POL_WEIGHTED: target_q <= target_inc;
        default:      idx_q <= (idx_q == n_last) ? '0 : idx_q + IDX_W'(1);
      endcase
    end
    if (cmd_i.finish) begin
      found_q  <= cmd_i.found;
      index_q  <= cmd_i.found ? sel : '0;
      reason_q <= cmd_i.reason;
    end
  end

  always_comb begin
    status_o.policy     = policy_q;
    status_o.enabled    = enabled_q;
    status_o.n_zero     = (n == '0);
    status_o.n_last     = n_last;
    status_o.total_zero = (total_q == '0);
    status_o.hit        = (policy_q == POL_WEIGHTED) ? alive_q[wsel] : use_idx;
    status_o.have       = have_q;
  end

  assign done_o         = done_q;
  assign found_o        = found_q;
  assign member_index_o = index_q;
  assign reason_o       = reason_q;

endmodule

@@ rtl/rms_ctrl.sv @@
// Controller: sequences the remainder, sum and member scan steps per request.
`timescale 1ns / 1ps

module rms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rms_pkg::dp_status_t status_i,
  output rms_pkg::dp_cmd_t    cmd_o
);
  import rms_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_WCHK  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_SINIT = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_FOEND = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [IDX_W-1:0]     k_q, k_d;
  logic [DIG_CNT_W-1:0] dig_q, dig_d;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    dig_d   = dig_q;
    cmd_o   = '0;
    cmd_o.k = k_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          k_d        = '0;
          if (!status_i.enabled) begin
            cmd_o.finish = 1'b1;
            cmd_o.reason = RS_DISABLED;
          end else if (status_i.n_zero) begin
            cmd_o.finish = 1'b1;
            cmd_o.reason = RS_NO_MEMBERS;
          end else begin
            case (status_i.policy)
              POL_FAILOVER: state_d = S_SCAN;
              POL_WEIGHTED: state_d = S_SUM;
              POL_HASH: begin
                cmd_o.mod_init     = 1'b1;
                cmd_o.mod_src_hash = 1'b1;
                dig_d              = HASH_DIG_LAST;
                state_d            = S_MOD;
              end
              default: begin
                cmd_o.mod_init = 1'b1;
                dig_d          = CUR_DIG_LAST;
                state_d        = S_MOD;
              end
            endcase
          end
        end
      end

      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (k_q == status_i.n_last) begin
          state_d = S_WCHK;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end

      S_WCHK: begin
        if (status_i.total_zero) begin
          cmd_o.finish = 1'b1;
          cmd_o.reason = RS_ZERO_WEIGHT;
          state_d      = S_IDLE;
        end else begin
          cmd_o.mod_init = 1'b1;
          dig_d          = CUR_DIG_LAST;
          state_d        = S_MOD;
        end
      end

      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (dig_q == '0) begin
          state_d = S_SINIT;
        end else begin
          dig_d = dig_q - DIG_CNT_W'(1);
        end
      end

      S_SINIT: begin
        cmd_o.scan_init = 1'b1;
        k_d             = '0;
        state_d         = S_SCAN;
      end

      S_SCAN: begin
        if (status_i.policy == POL_FAILOVER) begin
          cmd_o.scan_step = 1'b1;
          if (k_q == status_i.n_last) begin
            state_d = S_FOEND;
          end else begin
            k_d = k_q + IDX_W'(1);
          end
        end else if (status_i.hit) begin
          cmd_o.finish = 1'b1;
          cmd_o.found  = 1'b1;
          cmd_o.reason = RS_OK;
          state_d      = S_IDLE;
        end else if (k_q == status_i.n_last) begin
          cmd_o.finish = 1'b1;
          cmd_o.reason = RS_ALL_DEAD;
          state_d      = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
          k_d             = k_q + IDX_W'(1);
        end
      end

      S_FOEND: begin
        cmd_o.finish = 1'b1;
        cmd_o.found  = status_i.have;
        cmd_o.reason = status_i.have ? RS_OK : RS_ALL_DEAD;
        state_d      = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      dig_q   <= dig_d;
    end
  end

  assign busy = (state_q != S_IDLE);

`ifndef SYNTH
  a_mod_leads_to_scan_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && dig_q == '0) |=> (state_q == S_SINIT))
    else $error("remainder did not hand over to the scan");
  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_SUM) |-> (k_q <= status_i.n_last))
    else $error("member step ran past the member count");
`endif

endmodule

@@ rtl/route_member_selector.sv @@
// Top level of the route member selector: controller, datapath and ports.
`timescale 1ns / 1ps

// A disabled or empty set is answered straight from the idle state. Other
// requests step through the member count n (at most 8); a hash request first
// runs through the shared remainder unit, four hash bits a cycle.
// One word is in flight at a time; start is taken again in the done_o cycle,
// and the receiver cannot stall a result. Reset is asynchronous, active low.

module route_member_selector #(
  parameter int MAX_MEMBERS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request word.
  input  logic                            start,
  output logic                            busy,
  input  logic [rms_pkg::LANES-1:0]       alive_mask_i,
  input  logic [rms_pkg::DVD_W-1:0]       hash_value_i,
  // Result word, valid for the single cycle in which done_o is high.
  output logic                            done_o,
  output logic                            found_o,
  output logic [rms_pkg::IDX_W-1:0]       member_index_o,
  output logic [rms_pkg::REASON_W-1:0]    reason_o,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [rms_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rms_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import rms_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller walks each request through its steps: a member scan for
  // failover, a remainder of the cursor or hash followed by a circular scan
  // for round robin and hash, and a weight sum, cursor remainder and slot
  // retries for weighted selection.
  rms_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // The datapath holds the configuration, the selection cursor and the
  // registered result word.
  rms_datapath #(
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .alive_mask_i   (alive_mask_i),
    .hash_value_i   (hash_value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .done_o         (done_o),
    .found_o        (found_o),
    .member_index_o (member_index_o),
    .reason_o       (reason_o)
  );

`ifndef SYNTH
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word shown while a request is still in work");
  a_found_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (reason_o == RS_OK))
    else $error("selected member carries a failure reason");
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (member_index_o == '0 && reason_o != RS_OK))
    else $error("failed selection carries an index or an ok reason");
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request neither started nor answered");
`endif

endmodule
